// ----- hdl/ptsa_pkg.sv -----
// Shared types, codes and helpers for the page tag store.
package ptsa_pkg;

    localparam int STORE_WORDS_DEF = 4096;
    localparam int PAGE_W          = 44;
    localparam int MODE_W          = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int WORD_W          = 32;
    localparam int HALF_W          = 64;
    localparam int BANKS           = 4;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_UNTAGGED = 2'd1,
        STAT_OUTSIDE  = 2'd2
    } stat_t;

    localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_32  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_64  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_128 = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TAG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_PAGE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRAM_BASE  = 2'd3;

    typedef struct packed {
        logic       valid;
        stat_t      status;
        logic [1:0] lane;
    } chk_res_t;

    function automatic logic [2:0] words_of(input logic [MODE_W-1:0] mode);
        logic [2:0] w;
        case (mode)
            MODE_32: w = 3'd1;
            MODE_64: w = 3'd2;
            default: w = 3'd4;
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/ptsa_bank.sv -----
// One word bank of the tag store: single port, registered read.
module ptsa_bank import ptsa_pkg::*; #(
    parameter int DEPTH  = STORE_WORDS_DEF / BANKS,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WORD_W-1:0] wdata,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/ptsa_store.sv -----
// Four interleaved word banks with the post-reset clearing sweep.
module ptsa_store import ptsa_pkg::*; #(
    parameter int STORE_WORDS = STORE_WORDS_DEF,
    localparam int BANK_ROWS = (STORE_WORDS + BANKS - 1) / BANKS,
    localparam int ROW_W     = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [BANKS-1:0]             wr_en,
    input  logic                         rd_en,
    input  logic [ROW_W-1:0]             row,
    input  logic [BANKS-1:0][WORD_W-1:0] wdata,
    output logic [BANKS-1:0][WORD_W-1:0] rdata,
    output logic                         clear_busy
);

    logic             clr_busy_reg;
    logic [ROW_W-1:0] clr_row_reg;
    logic [ROW_W-1:0] bank_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end else if (clr_busy_reg) begin
            if (clr_row_reg == ROW_W'(BANK_ROWS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_row_reg <= clr_row_reg + 1'b1;
        end
    end

    assign bank_addr  = clr_busy_reg ? clr_row_reg : row;
    assign clear_busy = clr_busy_reg;

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        ptsa_bank #(
            .DEPTH  (BANK_ROWS),
            .ADDR_W (ROW_W)
        ) u_bank (
            .aclk  (aclk),
            .we    (clr_busy_reg | wr_en[b]),
            .re    (rd_en & ~clr_busy_reg),
            .addr  (bank_addr),
            .wdata (clr_busy_reg ? '0 : wdata[b]),
            .rdata (rdata[b])
        );
    end

endmodule

// ----- hdl/ptsa_check.sv -----
// Two-stage page range check and store address computation.
module ptsa_check import ptsa_pkg::*; #(
    parameter int STORE_WORDS = STORE_WORDS_DEF,
    localparam int BANK_ROWS = (STORE_WORDS + BANKS - 1) / BANKS,
    localparam int ROW_W     = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PAGE_W-1:0] page,
    input  logic [MODE_W-1:0] tag_mode,
    input  logic [PAGE_W-1:0] first_page,
    input  logic [PAGE_W-1:0] last_page,
    input  logic [PAGE_W-1:0] base_page,
    output chk_res_t          res,
    output logic [ROW_W-1:0]  row
);

    localparam int AW = $clog2(STORE_WORDS + 1);
    localparam int IW = AW + 3;

    logic              v1_reg;
    logic              untag_reg;
    logic              below_reg;
    logic [PAGE_W-1:0] off_reg;

    logic              v2_reg;
    stat_t             status_reg;
    logic [1:0]        lane_reg;
    logic [ROW_W-1:0]  row_reg;

    logic [2:0]        words;
    logic [IW-1:0]     idx;
    logic [IW-1:0]     idx_end;
    logic              off_far;
    logic              past_end;
    stat_t             status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    // stage 1: range compares and page offset
    always_ff @(posedge aclk) begin
        if (start) begin
            untag_reg <= (tag_mode == MODE_OFF) || (page < first_page) || (page > last_page);
            below_reg <= page < base_page;
            off_reg   <= page - base_page;
        end
    end

    // stage 2: store bounds
    always_comb begin
        words = words_of(tag_mode);
        case (tag_mode)
            MODE_32: idx = IW'(off_reg[AW-1:0]);
            MODE_64: idx = IW'({off_reg[AW-1:0], 1'b0});
            default: idx = IW'({off_reg[AW-1:0], 2'b00});
        endcase
        idx_end  = idx + IW'(words);
        off_far  = off_reg >= PAGE_W'(STORE_WORDS);
        past_end = idx_end > IW'(STORE_WORDS);
        if (untag_reg) begin
            status_next = STAT_UNTAGGED;
        end else if (below_reg || off_far || past_end) begin
            status_next = STAT_OUTSIDE;
        end else begin
            status_next = STAT_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            status_reg <= status_next;
            lane_reg   <= idx[1:0];
            row_reg    <= idx[ROW_W+1:2];
        end
    end

    assign res.valid  = v2_reg;
    assign res.status = status_reg;
    assign res.lane   = lane_reg;
    assign row        = row_reg;

endmodule

// ----- hdl/page_tag_store_access.sv -----
// Top level of the per-page tag store: stream ports, config registers, request sequencer.
// The block keeps one tag per physical page in an on-chip store of STORE_WORDS 32-bit words,
// split over four word banks so that a tag of up to four words is read or written in a single
// access. After reset a clearing sweep over all ceil(STORE_WORDS/4) bank rows (1024 at the
// default size) zeroes the store; no request word is taken until it ends. One request is handled
// at a time: a write or a refused request gives its result word after the two-stage range
// check, a read after the range check and the registered bank access; s_tready rises in the
// cycle the result word appears, so the next request can be taken in that same cycle. A result
// waiting on m_tready does not stop the next request from being accepted and checked. Config
// writes are taken in any cycle but must only be issued while no request is in flight.
module page_tag_store_access import ptsa_pkg::*; #(
    parameter int STORE_WORDS = STORE_WORDS_DEF,
    localparam int BANK_ROWS = (STORE_WORDS + BANKS - 1) / BANKS,
    localparam int ROW_W     = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PAGE_W-1:0]    cfg_data,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [175:0]         s_tdata,   // page_number, write_low, write_high, zero pad
    input  logic                 s_tuser,   // req_type

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [127:0]         m_tdata,   // read_low, read_high
    output logic [1:0]           m_tuser    // status
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CHK  = 4'b0010,
        ST_RD   = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [MODE_W-1:0] tag_mode_reg;
    logic [PAGE_W-1:0] first_page_reg;
    logic [PAGE_W-1:0] last_page_reg;
    logic [PAGE_W-1:0] base_page_reg;

    logic                  req_write_reg;
    logic [BANKS-1:0][WORD_W-1:0] wtag_reg;
    logic [1:0]            lane_reg;

    stat_t                 res_status_reg, res_status_next;
    logic [2*HALF_W-1:0]   res_data_reg, res_data_next;

    logic                  m_tvalid_reg;
    logic [1:0]            m_tuser_reg;
    logic [2*HALF_W-1:0]   m_tdata_reg;

    logic                  s_accept;
    logic                  out_load;
    chk_res_t              chk;
    logic [ROW_W-1:0]      chk_row;
    logic                  clear_busy;
    logic [BANKS-1:0]      store_wr;
    logic                  store_rd;
    logic [BANKS-1:0][WORD_W-1:0] store_wdata;
    logic [BANKS-1:0][WORD_W-1:0] store_rdata;
    logic [BANKS-1:0][WORD_W-1:0] rd_words;
    logic [2:0]            words;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_mode_reg   <= MODE_OFF;
            first_page_reg <= '0;
            last_page_reg  <= '0;
            base_page_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TAG_MODE:   tag_mode_reg   <= cfg_data[MODE_W-1:0];
                REG_FIRST_PAGE: first_page_reg <= cfg_data;
                REG_LAST_PAGE:  last_page_reg  <= cfg_data;
                REG_DRAM_BASE:  base_page_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !clear_busy;
    assign s_accept = s_tvalid && s_tready;
    assign words    = words_of(tag_mode_reg);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_write_reg <= s_tuser;
            wtag_reg      <= s_tdata[171:44];
        end
        if (state_reg == ST_CHK && chk.valid) begin
            lane_reg <= chk.lane;
        end
    end

    ptsa_check #(
        .STORE_WORDS (STORE_WORDS)
    ) u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_accept),
        .page       (s_tdata[43:0]),
        .tag_mode   (tag_mode_reg),
        .first_page (first_page_reg),
        .last_page  (last_page_reg),
        .base_page  (base_page_reg),
        .res        (chk),
        .row        (chk_row)
    );

    // tag word k lives in bank (lane + k)
    always_comb begin
        logic [1:0] k;
        for (int b = 0; b < BANKS; b++) begin
            k              = 2'(b) - chk.lane;
            store_wr[b]    = (state_reg == ST_CHK) && chk.valid && (chk.status == STAT_DONE)
                             && req_write_reg && ({1'b0, k} < words);
            store_wdata[b] = wtag_reg[k];
        end
        store_rd = (state_reg == ST_CHK) && chk.valid && (chk.status == STAT_DONE)
                   && !req_write_reg;
    end

    ptsa_store #(
        .STORE_WORDS (STORE_WORDS)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (store_wr),
        .rd_en      (store_rd),
        .row        (chk_row),
        .wdata      (store_wdata),
        .rdata      (store_rdata),
        .clear_busy (clear_busy)
    );

    always_comb begin
        logic [1:0] sel;
        for (int k = 0; k < BANKS; k++) begin
            sel         = lane_reg + 2'(k);
            rd_words[k] = (3'(k) < words) ? store_rdata[sel] : '0;
        end
    end

    assign out_load = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (chk.valid) begin
                    res_status_next = chk.status;
                    res_data_next   = '0;
                    if (chk.status == STAT_DONE && !req_write_reg) begin
                        state_next = ST_RD;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_RD: begin
                res_data_next = rd_words;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_load) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= res_data_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !s_tready)
        else $error("request accepted during store clear");

    a_access_only_when_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (store_rd || (store_wr != '0)) |-> (chk.status == STAT_DONE && !clear_busy))
        else $error("store accessed for a refused request");

    a_refused_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_DONE) |-> (m_tdata == '0))
        else $error("refused request returned tag data");

    a_read_follows_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |-> $past(store_rd))
        else $error("read data used without a read");
`endif

endmodule
